>>> rtl/core/sora_pkg.sv
// Shared types, constants and fixed-point helpers for the rotational anisotropy pipeline.
package sora_pkg;

    // Table geometry
    localparam int MATERIALS = 16;
    localparam int MAT_AW    = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;
    localparam int MAT_CW    = 9;
    localparam int AXES      = 3;
    localparam int NUM_WORDS = 2 * AXES + 1;
    localparam int WORD_W    = 32;

    // Fixed-point widths and shifts
    localparam int PROD_W    = 34;   // asr(s*f, 30)
    localparam int PSUM_W    = 35;   // sum of three projections
    localparam int S_W       = 29;   // Sx, Sy in Q.24
    localparam int KF_W      = 28;   // asr(k*f, 36)
    localparam int K6_W      = 26;   // asr(k, 6)
    localparam int SAT_IN_W  = 40;
    localparam int PART_W    = 36;   // asr(a*kf, 24)
    localparam int EPART_W   = 34;   // asr(w*k6, 24)
    localparam int FIELD_W   = 41;
    localparam int ENERGY_W  = 36;
    localparam int OUT_W     = 48;

    localparam int SH_AXIS   = 30;
    localparam int SH_DOWN   = 6;
    localparam int SH_KAXIS  = 36;
    localparam int SH_FRAC   = 24;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -40'sd2147483648;

    localparam logic signed [SAT_IN_W-1:0] C_THREE = 40'sd3;
    localparam logic signed [SAT_IN_W-1:0] C_FIVE  = 40'sd5;
    localparam logic signed [SAT_IN_W-1:0] C_TEN   = 40'sd10;
    localparam logic signed [FIELD_W-1:0]  C_SIX   = 41'sd6;
    localparam logic signed [ENERGY_W-1:0] C_NTWO  = -36'sd2;

    typedef enum logic [1:0] {
        ACT_FIELD  = 2'd0,
        ACT_ENERGY = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_IDLE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        WSEL_FX = 3'd0,
        WSEL_FY = 3'd1,
        WSEL_FZ = 3'd2,
        WSEL_GX = 3'd3,
        WSEL_GY = 3'd4,
        WSEL_GZ = 3'd5,
        WSEL_K  = 3'd6
    } t_wsel;

    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_ENERGY = 1'b1;

    typedef struct packed {
        logic [1:0]                action;
        logic [3:0]                material;
        logic [2:0]                word_select;
        logic signed [WORD_W-1:0]  word_value;
        logic signed [WORD_W-1:0]  spin_x;
        logic signed [WORD_W-1:0]  spin_y;
        logic signed [WORD_W-1:0]  spin_z;
        logic                      last_atom;
    } t_req;

    typedef struct packed {
        logic                      result_kind;
        logic signed [OUT_W-1:0]   field_dx;
        logic signed [OUT_W-1:0]   field_dy;
        logic signed [OUT_W-1:0]   field_dz;
        logic signed [OUT_W-1:0]   energy;
        logic                      last_out;
    } t_rsp;

    typedef logic [AXES-1:0][WORD_W-1:0] t_vec;

    typedef struct packed {
        t_vec              f;
        t_vec              g;
        logic [WORD_W-1:0] k;
    } t_row;

    typedef struct packed {
        logic is_energy;
        logic last;
    } t_tag;

    typedef struct packed {
        logic [AXES-1:0][KF_W-1:0] kf;
        logic [AXES-1:0][KF_W-1:0] kg;
        logic [K6_W-1:0]           k6;
    } t_scale;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end else begin
            r = x[WORD_W-1:0];
        end
        return r;
    endfunction

    // Q.24 product, floor shift, clamp to 32 bits
    function automatic logic signed [WORD_W-1:0] mul_q24(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [2*WORD_W-1:0] p;
        p = a * b;
        return sat32(SAT_IN_W'(p >>> SH_FRAC));
    endfunction

endpackage

>>> rtl/core/sora_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sora_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sora_table.sv
// Material table: write decode, per-word RAMs and the table read stage.
module sora_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sora_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output sora_pkg::t_tag  o_tag,
    output sora_pkg::t_vec  o_spin,
    output sora_pkg::t_row  o_row
);
    import sora_pkg::*;

    logic                              en;
    logic                              accept;
    logic                              mat_ok;
    logic                              is_calc;
    logic [MAT_AW-1:0]                 addr;
    logic [NUM_WORDS-1:0]              we;
    logic [NUM_WORDS-1:0][WORD_W-1:0]  rdata;
    logic                              r_valid;
    logic                              r_ok;
    t_tag                              r_tag;
    t_vec                              r_spin;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign accept  = i_valid && en;
    assign mat_ok  = {{(MAT_CW-4){1'b0}}, i_req.material} < MAT_CW'(MATERIALS);
    assign is_calc = (i_req.action == ACT_FIELD) || (i_req.action == ACT_ENERGY);
    assign addr    = MAT_AW'(i_req.material);

    always_comb begin
        we = '0;
        if (accept && i_req.action == ACT_WRITE && mat_ok) begin
            case (i_req.word_select)
                WSEL_FX: we[WSEL_FX] = 1'b1;
                WSEL_FY: we[WSEL_FY] = 1'b1;
                WSEL_FZ: we[WSEL_FZ] = 1'b1;
                WSEL_GX: we[WSEL_GX] = 1'b1;
                WSEL_GY: we[WSEL_GY] = 1'b1;
                WSEL_GZ: we[WSEL_GZ] = 1'b1;
                WSEL_K:  we[WSEL_K]  = 1'b1;
                default: we = '0;
            endcase
        end
    end

    for (genvar j = 0; j < NUM_WORDS; j++) begin : g_word
        sora_ram #(
            .WIDTH (WORD_W),
            .DEPTH (MATERIALS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[j]),
            .i_waddr (addr),
            .i_wdata (i_req.word_value),
            .i_re    (en),
            .i_raddr (addr),
            .o_rdata (rdata[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= accept && is_calc;
        end
        if (en) begin
            r_ok          <= mat_ok;
            r_tag.is_energy <= (i_req.action == ACT_ENERGY);
            r_tag.last    <= i_req.last_atom;
            r_spin[0]     <= i_req.spin_x;
            r_spin[1]     <= i_req.spin_y;
            r_spin[2]     <= i_req.spin_z;
        end
    end

    // materials past the table read as zero
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            o_row.f[i] = r_ok ? rdata[i] : '0;
            o_row.g[i] = r_ok ? rdata[AXES+i] : '0;
        end
        o_row.k = r_ok ? rdata[2*AXES] : '0;
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_spin  = r_spin;

endmodule

>>> rtl/core/sora_proj.sv
// Projection stages: spin onto local axes, plus constant-scaled axis terms.
module sora_proj (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  sora_pkg::t_tag                          i_tag,
    input  sora_pkg::t_vec                          i_spin,
    input  sora_pkg::t_row                          i_row,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output sora_pkg::t_tag                          o_tag,
    output logic signed [sora_pkg::S_W-1:0]         o_sx,
    output logic signed [sora_pkg::S_W-1:0]         o_sy,
    output sora_pkg::t_scale                        o_scale
);
    import sora_pkg::*;

    logic                       en2;
    logic                       en3;
    logic signed [2*WORD_W-1:0] prod_f  [AXES];
    logic signed [2*WORD_W-1:0] prod_g  [AXES];
    logic signed [2*WORD_W-1:0] prod_kf [AXES];
    logic signed [2*WORD_W-1:0] prod_kg [AXES];
    logic signed [PROD_W-1:0]   n2_pf   [AXES];
    logic signed [PROD_W-1:0]   n2_pg   [AXES];
    t_scale                     n2_scale;
    logic signed [PSUM_W-1:0]   sum_f;
    logic signed [PSUM_W-1:0]   sum_g;

    logic                       r2_valid;
    t_tag                       r2_tag;
    logic signed [PROD_W-1:0]   r2_pf   [AXES];
    logic signed [PROD_W-1:0]   r2_pg   [AXES];
    t_scale                     r2_scale;

    logic                       r3_valid;
    t_tag                       r3_tag;
    logic signed [S_W-1:0]      r3_sx;
    logic signed [S_W-1:0]      r3_sy;
    t_scale                     r3_scale;

    assign en3     = !r3_valid || i_ready;
    assign en2     = !r2_valid || en3;
    assign o_ready = en2;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            prod_f[i]      = $signed(i_spin[i]) * $signed(i_row.f[i]);
            prod_g[i]      = $signed(i_spin[i]) * $signed(i_row.g[i]);
            prod_kf[i]     = $signed(i_row.k) * $signed(i_row.f[i]);
            prod_kg[i]     = $signed(i_row.k) * $signed(i_row.g[i]);
            n2_pf[i]       = PROD_W'(prod_f[i] >>> SH_AXIS);
            n2_pg[i]       = PROD_W'(prod_g[i] >>> SH_AXIS);
            n2_scale.kf[i] = KF_W'(prod_kf[i] >>> SH_KAXIS);
            n2_scale.kg[i] = KF_W'(prod_kg[i] >>> SH_KAXIS);
        end
        n2_scale.k6 = K6_W'($signed(i_row.k) >>> SH_DOWN);
    end

    // each projection term is floored before the sum, then the sum again
    assign sum_f = PSUM_W'(r2_pf[0]) + PSUM_W'(r2_pf[1]) + PSUM_W'(r2_pf[2]);
    assign sum_g = PSUM_W'(r2_pg[0]) + PSUM_W'(r2_pg[1]) + PSUM_W'(r2_pg[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= i_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
        end
        if (en2) begin
            r2_tag   <= i_tag;
            r2_pf    <= n2_pf;
            r2_pg    <= n2_pg;
            r2_scale <= n2_scale;
        end
        if (en3) begin
            r3_tag   <= r2_tag;
            r3_sx    <= S_W'(sum_f >>> SH_DOWN);
            r3_sy    <= S_W'(sum_g >>> SH_DOWN);
            r3_scale <= r2_scale;
        end
    end

    assign o_valid = r3_valid;
    assign o_tag   = r3_tag;
    assign o_sx    = r3_sx;
    assign o_sy    = r3_sy;
    assign o_scale = r3_scale;

endmodule

>>> rtl/core/sora_poly.sv
// Power stages: squares, fourth powers and the three saturated polynomials.
module sora_poly (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  sora_pkg::t_tag                          i_tag,
    input  logic signed [sora_pkg::S_W-1:0]         i_sx,
    input  logic signed [sora_pkg::S_W-1:0]         i_sy,
    input  sora_pkg::t_scale                        i_scale,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output sora_pkg::t_tag                          o_tag,
    output logic signed [sora_pkg::S_W-1:0]         o_sx,
    output logic signed [sora_pkg::S_W-1:0]         o_sy,
    output logic signed [sora_pkg::WORD_W-1:0]      o_sxy,
    output logic signed [sora_pkg::WORD_W-1:0]      o_px,
    output logic signed [sora_pkg::WORD_W-1:0]      o_py,
    output logic signed [sora_pkg::WORD_W-1:0]      o_pe,
    output sora_pkg::t_scale                        o_scale
);
    import sora_pkg::*;

    logic                         en4;
    logic                         en5;
    logic                         en6;
    logic signed [SAT_IN_W-1:0]   e_sx4;
    logic signed [SAT_IN_W-1:0]   e_sy4;
    logic signed [SAT_IN_W-1:0]   e_sxy2;
    logic signed [SAT_IN_W-1:0]   sum_px;
    logic signed [SAT_IN_W-1:0]   sum_py;
    logic signed [SAT_IN_W-1:0]   sum_pe;

    logic                         r4_valid;
    t_tag                         r4_tag;
    logic signed [S_W-1:0]        r4_sx;
    logic signed [S_W-1:0]        r4_sy;
    logic signed [WORD_W-1:0]     r4_sx2;
    logic signed [WORD_W-1:0]     r4_sy2;
    logic signed [WORD_W-1:0]     r4_sxy;
    t_scale                       r4_scale;

    logic                         r5_valid;
    t_tag                         r5_tag;
    logic signed [S_W-1:0]        r5_sx;
    logic signed [S_W-1:0]        r5_sy;
    logic signed [WORD_W-1:0]     r5_sxy;
    logic signed [WORD_W-1:0]     r5_sx4;
    logic signed [WORD_W-1:0]     r5_sy4;
    logic signed [WORD_W-1:0]     r5_sxy2;
    t_scale                       r5_scale;

    logic                         r6_valid;
    t_tag                         r6_tag;
    logic signed [S_W-1:0]        r6_sx;
    logic signed [S_W-1:0]        r6_sy;
    logic signed [WORD_W-1:0]     r6_sxy;
    logic signed [WORD_W-1:0]     r6_px;
    logic signed [WORD_W-1:0]     r6_py;
    logic signed [WORD_W-1:0]     r6_pe;
    t_scale                       r6_scale;

    assign en6     = !r6_valid || i_ready;
    assign en5     = !r5_valid || en6;
    assign en4     = !r4_valid || en5;
    assign o_ready = en4;

    assign e_sx4  = SAT_IN_W'(r5_sx4);
    assign e_sy4  = SAT_IN_W'(r5_sy4);
    assign e_sxy2 = SAT_IN_W'(r5_sxy2);
    assign sum_px = C_FIVE * e_sx4 - C_TEN * e_sxy2 + e_sy4;
    assign sum_py = e_sx4 - C_TEN * e_sxy2 + C_FIVE * e_sy4;
    assign sum_pe = C_THREE * e_sx4 - C_TEN * e_sxy2 + C_THREE * e_sy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else begin
            if (en4) begin
                r4_valid <= i_valid;
            end
            if (en5) begin
                r5_valid <= r4_valid;
            end
            if (en6) begin
                r6_valid <= r5_valid;
            end
        end
        if (en4) begin
            r4_tag   <= i_tag;
            r4_sx    <= i_sx;
            r4_sy    <= i_sy;
            r4_sx2   <= mul_q24(WORD_W'(i_sx), WORD_W'(i_sx));
            r4_sy2   <= mul_q24(WORD_W'(i_sy), WORD_W'(i_sy));
            r4_sxy   <= mul_q24(WORD_W'(i_sx), WORD_W'(i_sy));
            r4_scale <= i_scale;
        end
        if (en5) begin
            r5_tag   <= r4_tag;
            r5_sx    <= r4_sx;
            r5_sy    <= r4_sy;
            r5_sxy   <= r4_sxy;
            r5_sx4   <= mul_q24(r4_sx2, r4_sx2);
            r5_sy4   <= mul_q24(r4_sy2, r4_sy2);
            r5_sxy2  <= mul_q24(r4_sx2, r4_sy2);
            r5_scale <= r4_scale;
        end
        if (en6) begin
            r6_tag   <= r5_tag;
            r6_sx    <= r5_sx;
            r6_sy    <= r5_sy;
            r6_sxy   <= r5_sxy;
            r6_px    <= sat32(sum_px);
            r6_py    <= sat32(sum_py);
            r6_pe    <= sat32(sum_pe);
            r6_scale <= r5_scale;
        end
    end

    assign o_valid = r6_valid;
    assign o_tag   = r6_tag;
    assign o_sx    = r6_sx;
    assign o_sy    = r6_sy;
    assign o_sxy   = r6_sxy;
    assign o_px    = r6_px;
    assign o_py    = r6_py;
    assign o_pe    = r6_pe;
    assign o_scale = r6_scale;

endmodule

>>> rtl/core/sora_field.sv
// Output stages: field and energy products, final scaling and the result register.
module sora_field (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_enable,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  sora_pkg::t_tag                          i_tag,
    input  logic signed [sora_pkg::S_W-1:0]         i_sx,
    input  logic signed [sora_pkg::S_W-1:0]         i_sy,
    input  logic signed [sora_pkg::WORD_W-1:0]      i_sxy,
    input  logic signed [sora_pkg::WORD_W-1:0]      i_px,
    input  logic signed [sora_pkg::WORD_W-1:0]      i_py,
    input  logic signed [sora_pkg::WORD_W-1:0]      i_pe,
    input  sora_pkg::t_scale                        i_scale,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output sora_pkg::t_rsp                          o_rsp
);
    import sora_pkg::*;

    logic                         en7;
    logic                         en8;
    logic                         en9;
    logic signed [2*WORD_W-1:0]   prod_a [AXES];
    logic signed [2*WORD_W-1:0]   prod_b [AXES];
    logic signed [2*WORD_W-1:0]   prod_e;
    logic signed [FIELD_W-1:0]    fsum   [AXES];
    logic signed [FIELD_W-1:0]    fval   [AXES];
    logic signed [ENERGY_W-1:0]   eval_q;
    logic                         field_on;
    t_rsp                         n9_rsp;

    logic                         r7_valid;
    t_tag                         r7_tag;
    logic signed [WORD_W-1:0]     r7_a;
    logic signed [WORD_W-1:0]     r7_b;
    logic signed [WORD_W-1:0]     r7_w;
    t_scale                       r7_scale;

    logic                         r8_valid;
    t_tag                         r8_tag;
    logic signed [PART_W-1:0]     r8_pa [AXES];
    logic signed [PART_W-1:0]     r8_pb [AXES];
    logic signed [EPART_W-1:0]    r8_pe;

    logic                         r9_valid;
    t_rsp                         r9_rsp;

    assign en9     = !r9_valid || i_ready;
    assign en8     = !r8_valid || en9;
    assign en7     = !r7_valid || en8;
    assign o_ready = en7;

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            prod_a[i] = r7_a * $signed(r7_scale.kf[i]);
            prod_b[i] = r7_b * $signed(r7_scale.kg[i]);
        end
        prod_e = r7_w * $signed(r7_scale.k6);
    end

    assign field_on = i_enable && !r8_tag.is_energy;
    assign eval_q   = C_NTWO * ENERGY_W'(r8_pe);

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            fsum[i] = FIELD_W'(r8_pa[i]) + FIELD_W'(r8_pb[i]);
            fval[i] = C_SIX * fsum[i];
        end
        n9_rsp.result_kind = r8_tag.is_energy ? KIND_ENERGY : KIND_FIELD;
        n9_rsp.field_dx    = field_on ? OUT_W'(fval[0]) : '0;
        n9_rsp.field_dy    = field_on ? OUT_W'(fval[1]) : '0;
        n9_rsp.field_dz    = field_on ? OUT_W'(fval[2]) : '0;
        n9_rsp.energy      = r8_tag.is_energy ? OUT_W'(eval_q) : '0;
        n9_rsp.last_out    = r8_tag.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else begin
            if (en7) begin
                r7_valid <= i_valid;
            end
            if (en8) begin
                r8_valid <= r7_valid;
            end
            if (en9) begin
                r9_valid <= r8_valid;
            end
        end
        if (en7) begin
            r7_tag   <= i_tag;
            r7_a     <= mul_q24(WORD_W'(i_sy), i_px);
            r7_b     <= mul_q24(WORD_W'(i_sx), i_py);
            r7_w     <= mul_q24(i_sxy, i_pe);
            r7_scale <= i_scale;
        end
        if (en8) begin
            r8_tag <= r7_tag;
            for (int i = 0; i < AXES; i++) begin
                r8_pa[i] <= PART_W'(prod_a[i] >>> SH_FRAC);
                r8_pb[i] <= PART_W'(prod_b[i] >>> SH_FRAC);
            end
            r8_pe <= EPART_W'(prod_e >>> SH_FRAC);
        end
        if (en9) begin
            r9_rsp <= n9_rsp;
        end
    end

    assign o_valid = r9_valid;
    assign o_rsp   = r9_rsp;

endmodule

>>> rtl/core/sixth_order_rotational_anisotropy.sv
// Top level of the sixth-order odd rotational anisotropy pipeline.
// Each field or energy request returns one result from the result register; the pipeline
// takes one request per clock and keeps up to nine in flight, so a steady stream moves at one
// atom per cycle while the result side is ready. The material table read (one registered RAM
// per table word, depth MATERIALS) sits in the first stage, followed by two projection stages,
// three power and polynomial stages, and three product and output stages ending in the result
// register. Table writes give no result; a request that follows a write in
// the next cycle already sees the new word. Materials past the table end read as zero, and the
// enable register forces field increments to zero without affecting energy results.
module sixth_order_rotational_anisotropy (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sora_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output sora_pkg::t_rsp  o_rsp
);
    import sora_pkg::*;

    logic                     r_enable;

    logic                     tb_valid;
    logic                     tb_ready;
    t_tag                     tb_tag;
    t_vec                     tb_spin;
    t_row                     tb_row;

    logic                     pj_valid;
    logic                     pj_ready;
    t_tag                     pj_tag;
    logic signed [S_W-1:0]    pj_sx;
    logic signed [S_W-1:0]    pj_sy;
    t_scale                   pj_scale;

    logic                     pl_valid;
    logic                     pl_ready;
    t_tag                     pl_tag;
    logic signed [S_W-1:0]    pl_sx;
    logic signed [S_W-1:0]    pl_sy;
    logic signed [WORD_W-1:0] pl_sxy;
    logic signed [WORD_W-1:0] pl_px;
    logic signed [WORD_W-1:0] pl_py;
    logic signed [WORD_W-1:0] pl_pe;
    t_scale                   pl_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_data;
        end
    end

    sora_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .o_valid (tb_valid),
        .i_ready (tb_ready),
        .o_tag   (tb_tag),
        .o_spin  (tb_spin),
        .o_row   (tb_row)
    );

    sora_proj u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (tb_valid),
        .o_ready (tb_ready),
        .i_tag   (tb_tag),
        .i_spin  (tb_spin),
        .i_row   (tb_row),
        .o_valid (pj_valid),
        .i_ready (pj_ready),
        .o_tag   (pj_tag),
        .o_sx    (pj_sx),
        .o_sy    (pj_sy),
        .o_scale (pj_scale)
    );

    sora_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pj_valid),
        .o_ready (pj_ready),
        .i_tag   (pj_tag),
        .i_sx    (pj_sx),
        .i_sy    (pj_sy),
        .i_scale (pj_scale),
        .o_valid (pl_valid),
        .i_ready (pl_ready),
        .o_tag   (pl_tag),
        .o_sx    (pl_sx),
        .o_sy    (pl_sy),
        .o_sxy   (pl_sxy),
        .o_px    (pl_px),
        .o_py    (pl_py),
        .o_pe    (pl_pe),
        .o_scale (pl_scale)
    );

    sora_field u_field (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (r_enable),
        .i_valid  (pl_valid),
        .o_ready  (pl_ready),
        .i_tag    (pl_tag),
        .i_sx     (pl_sx),
        .i_sy     (pl_sy),
        .i_sxy    (pl_sxy),
        .i_px     (pl_px),
        .i_py     (pl_py),
        .i_pe     (pl_pe),
        .i_scale  (pl_scale),
        .o_valid  (o_rsp_valid),
        .i_ready  (i_rsp_ready),
        .o_rsp    (o_rsp)
    );

    // an empty result register must let the whole pipe move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp_valid |-> o_req_ready)
        else $error("request side stalled with an empty result register");

    a_energy_no_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.result_kind == KIND_ENERGY |->
            o_rsp.field_dx == '0 && o_rsp.field_dy == '0 && o_rsp.field_dz == '0)
        else $error("energy result carries a field increment");

    a_disabled_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !r_enable && o_rsp.result_kind == KIND_FIELD |->
            o_rsp.field_dx == '0 && o_rsp.field_dy == '0 && o_rsp.field_dz == '0
            && o_rsp.energy == '0)
        else $error("field result not zero while disabled");

endmodule
